/* rtl/julia_escape_time_pixel_unit_macros.svh */
// Assertion macros for the Julia escape-time pixel unit
`ifndef JULIA_ESCAPE_TIME_PIXEL_UNIT_MACROS_SVH
`define JULIA_ESCAPE_TIME_PIXEL_UNIT_MACROS_SVH
// Implication checked on every clock edge outside reset
`define JET_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication checked in the next cycle
`define JET_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* rtl/jet_pkg.sv */
// -----------------------------------------------------------------------------
// jet_pkg
// Shared constants and types for the Julia escape-time pixel unit.
// -----------------------------------------------------------------------------
package jet_pkg;
  localparam int Cols = 1024;
  localparam int Rows = 1024;
  localparam int RowW = 10;
  localparam int ColW = 10;
  localparam int CntW = 16;
  localparam int QW   = 32;

  localparam logic [2:0] RegZoom  = 3'd0;
  localparam logic [2:0] RegCtrX  = 3'd1;
  localparam logic [2:0] RegCtrY  = 3'd2;
  localparam logic [2:0] RegCRe   = 3'd3;
  localparam logic [2:0] RegCIm   = 3'd4;
  localparam logic [2:0] RegLimit = 3'd5;

  localparam int ColDen = (Cols - 2) / 2;
  localparam int RowDen = (Rows - 2) / 2;

  // Start point of one pixel, handed from front to back
  typedef struct packed {
    logic signed [QW-1:0] x;
    logic signed [QW-1:0] y;
  } start_t;

  // Saturate a wide signed value into Q4.28
  function automatic logic signed [QW-1:0] sat_q(input logic signed [67:0] v);
    logic signed [67:0] mx;
    logic signed [67:0] mn;
    mx = 68'sh0_0000_0000_7FFF_FFFF;
    mn = -68'sh0_0000_0000_8000_0000;
    if (v > mx) sat_q = QW'(mx);
    else if (v < mn) sat_q = QW'(mn);
    else sat_q = v[QW-1:0];
  endfunction
endpackage

/* rtl/jet_front.sv */
// -----------------------------------------------------------------------------
// jet_front
// Maps a pixel to its start point with a restoring divider, two coordinates
// in turn (64 quotient bits each).
// -----------------------------------------------------------------------------
module jet_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  output logic                  full_o,
  input  logic [jet_pkg::RowW-1:0] pixel_row_i,
  input  logic [jet_pkg::ColW-1:0] pixel_col_i,
  input  logic [31:0]           zoom_i,
  input  logic [31:0]           ctr_x_i,
  input  logic [31:0]           ctr_y_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output jet_pkg::start_t       out_data_o
);
  import jet_pkg::*;

  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SDiv  = 2'd1;
  localparam logic [1:0] SOut  = 2'd2;

  logic [1:0]  state_q, state_d;
  logic        axis_q, axis_d;        // 0: x, 1: y
  logic [6:0]  bit_q, bit_d;
  logic [63:0] num_q, num_d;          // dividend shifting out
  logic [63:0] quo_q, quo_d;
  logic [64:0] rem_q, rem_d;
  logic [63:0] den_q, den_d;
  logic        neg_q, neg_d;
  logic [RowW-1:0] row_q, row_d;
  logic signed [QW-1:0] x_q, x_d;
  logic signed [QW-1:0] y_q, y_d;

  logic signed [13:0] nx, ny;
  logic [13:0]  nxm, nym;
  logic [31:0]  zoom_eff;
  logic [64:0]  rem_sh;
  logic signed [67:0] coord_w;
  logic signed [QW-1:0] coord;

  assign zoom_eff = (zoom_i == '0) ? 32'd1 : zoom_i;
  assign nx = 14'((14'(pixel_col_i) - 14'(Cols / 2) + 14'sd1) * 14'sd2);
  assign ny = 14'((14'(Rows / 2) - 14'(row_q) - 14'sd1) * 14'sd2);
  assign nxm = nx[13] ? 14'(-nx) : nx;
  assign nym = ny[13] ? 14'(-ny) : ny;
  assign rem_sh = {rem_q[63:0], num_q[63]};

  // Clamp the quotient into Q4.28, apply the sign and take off the center
  always_comb begin
    logic signed [67:0] q;
    q = (quo_q > 64'h7FFF_FFFF) ? (neg_q ? 68'sh8000_0000 : 68'sh7FFF_FFFF)
                                : 68'(quo_q);
    if (neg_q) q = -q;
    coord_w = q - 68'(signed'(axis_q ? ctr_y_i : ctr_x_i));
    coord = sat_q(coord_w);
  end

  always_comb begin
    state_d = state_q; axis_d = axis_q; bit_d = bit_q; num_d = num_q;
    quo_d = quo_q; rem_d = rem_q; den_d = den_q; neg_d = neg_q;
    row_d = row_q; x_d = x_q; y_d = y_q;
    unique case (state_q)
      SIdle: begin
        if (push_i) begin
          row_d = pixel_row_i; axis_d = 1'b0;
          num_d = 64'(nxm) << 44; neg_d = nx[13];
          den_d = 64'(ColDen) * 64'(zoom_eff);
          rem_d = '0; quo_d = '0; bit_d = '0; state_d = SDiv;
        end
      end
      SDiv: begin
        // Advance one quotient bit
        num_d = num_q << 1;
        if (rem_sh >= {1'b0, den_q}) begin
          rem_d = rem_sh - {1'b0, den_q}; quo_d = {quo_q[62:0], 1'b1};
        end else begin
          rem_d = rem_sh; quo_d = {quo_q[62:0], 1'b0};
        end
        bit_d = bit_q + 7'd1;
        if (bit_q == 7'd64) begin
          rem_d = rem_q; quo_d = quo_q; num_d = num_q;
          if (!axis_q) begin
            x_d = coord; axis_d = 1'b1;
            num_d = 64'(nym) << 44; neg_d = ny[13];
            den_d = 64'(RowDen) * 64'(zoom_eff);
            rem_d = '0; quo_d = '0; bit_d = '0;
          end else begin
            y_d = coord; state_d = SOut;
          end
        end
      end
      SOut: if (out_ready_i) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  // Advance control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; axis_q <= 1'b0; bit_q <= '0;
    end else begin
      state_q <= state_d; axis_q <= axis_d; bit_q <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d; quo_q <= quo_d; rem_q <= rem_d; den_q <= den_d;
    neg_q <= neg_d; row_q <= row_d; x_q <= x_d; y_q <= y_d;
  end

  assign full_o = (state_q != SIdle);
  assign out_valid_o = (state_q == SOut);
  assign out_data_o = '{x: x_q, y: y_q};
endmodule

/* rtl/jet_fifo.sv */
// -----------------------------------------------------------------------------
// jet_fifo
// Two-entry queue between the front and the back.
// -----------------------------------------------------------------------------
module jet_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_i,
  output logic            wr_ready_o,
  input  jet_pkg::start_t wr_data_i,
  output logic            rd_valid_o,
  input  logic            rd_i,
  output jet_pkg::start_t rd_data_o
);
  import jet_pkg::*;

  start_t     mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       do_wr, do_rd;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign do_wr = wr_i && wr_ready_o;
  assign do_rd = rd_i && rd_valid_o;
  assign rd_data_o = mem_q[rp_q];

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (do_wr) wp_q <= ~wp_q;
      if (do_rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(do_wr) - 2'(do_rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wp_q] <= wr_data_i;
  end
endmodule

/* rtl/jet_back.sv */
// -----------------------------------------------------------------------------
// jet_back
// Iterates z = z^2 + c: multiply step, update step, then escape test step.
// -----------------------------------------------------------------------------
module jet_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  jet_pkg::start_t in_data_i,
  input  logic [31:0]     c_re_i,
  input  logic [31:0]     c_im_i,
  input  logic [15:0]     limit_i,
  output logic            empty_o,
  input  logic            pop_i,
  output logic [jet_pkg::CntW-1:0] escape_count_o
);
  import jet_pkg::*;

  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SMul  = 2'd1;
  localparam logic [1:0] SUpd  = 2'd2;
  localparam logic [1:0] SSq   = 2'd3;

  logic [1:0]  state_q;
  logic signed [QW-1:0] x_q, y_q;
  logic signed [63:0] xx_q, yy_q, xy_q;
  logic [CntW-1:0] cnt_q;
  logic        res_v_q;
  logic [CntW-1:0] res_q;
  logic        ret;
  logic signed [67:0] nr_w, ni_w;
  logic signed [QW-1:0] nr, ni;
  logic signed [64:0] dxy;
  logic [64:0] mag2;

  assign ret = !res_v_q || pop_i;
  assign in_ready_o = (state_q == SIdle) && ret;
  assign dxy = 65'(xx_q) - 65'(yy_q);
  assign nr_w = 68'(dxy >>> 28) + 68'(signed'(c_re_i));
  assign ni_w = 68'(xy_q >>> 27) + 68'(signed'(c_im_i));
  assign nr = sat_q(nr_w);
  assign ni = sat_q(ni_w);
  assign mag2 = 65'(unsigned'(xx_q)) + 65'(unsigned'(yy_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; res_v_q <= 1'b0;
    end else begin
      if (pop_i && res_v_q) res_v_q <= 1'b0;
      unique case (state_q)
        SIdle: if (in_valid_i && ret) begin
          if (limit_i == '0) res_v_q <= 1'b1;
          else state_q <= SMul;
        end
        SMul: state_q <= SUpd;
        SUpd: state_q <= SSq;
        SSq: begin
          // Escape when the new magnitude tops four, or stop at the iteration limit
          if (mag2 > 65'h400_0000_0000_0000 || cnt_q + 16'd1 == limit_i) begin
            state_q <= SIdle; res_v_q <= 1'b1;
          end else state_q <= SMul;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      SIdle: if (in_valid_i && ret) begin
        x_q <= in_data_i.x; y_q <= in_data_i.y; cnt_q <= '0; res_q <= '0;
      end
      SMul: begin
        xx_q <= x_q * x_q; yy_q <= y_q * y_q; xy_q <= x_q * y_q;
      end
      SUpd: begin
        x_q <= nr; y_q <= ni;
        xx_q <= nr * nr; yy_q <= ni * ni;
      end
      SSq: begin
        res_q <= (mag2 > 65'h400_0000_0000_0000) ? cnt_q : cnt_q + 16'd1;
        cnt_q <= cnt_q + 16'd1;
      end
      default: ;
    endcase
  end

  assign empty_o = !res_v_q;
  assign escape_count_o = res_q;
endmodule

/* rtl/julia_escape_time_pixel_unit.sv */
// -----------------------------------------------------------------------------
// julia_escape_time_pixel_unit
// Escape-time count of one Julia-set pixel.
//
// Channel  Handshake                  Payload
// input    push_i / full_o            pixel_row_i, pixel_col_i
// result   pop_i / empty_o            escape_count_o
// config   cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// Front: 65 divider steps per coordinate, then it holds the start point until
// the queue takes it and goes idle; it takes no new pixel until idle again.
// Back: each iteration runs a multiply, an update and an escape test step, and
// the back then goes idle to take the next start point; a zero limit ends in idle.
// A two-entry queue lets the front run ahead; a waiting result stalls the back.
// Reset is asynchronous, clears control state and sets config registers to defaults.
// -----------------------------------------------------------------------------
module julia_escape_time_pixel_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  output logic        full_o,
  input  logic [jet_pkg::RowW-1:0] pixel_row_i,
  input  logic [jet_pkg::ColW-1:0] pixel_col_i,
  output logic        empty_o,
  input  logic        pop_i,
  output logic [jet_pkg::CntW-1:0] escape_count_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import jet_pkg::*;

  logic [31:0] zoom_q, cx_q, cy_q, cre_q, cim_q;
  logic [15:0] lim_q;
  logic f_v, f_r, q_v, q_r;
  start_t f_d, q_d;

  assign cfg_ready_o = 1'b1;

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zoom_q <= 32'd65536; cx_q <= '0; cy_q <= '0;
      cre_q <= '0; cim_q <= '0; lim_q <= 16'd255;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegZoom:  zoom_q <= cfg_data_i;
        RegCtrX:  cx_q <= cfg_data_i;
        RegCtrY:  cy_q <= cfg_data_i;
        RegCRe:   cre_q <= cfg_data_i;
        RegCIm:   cim_q <= cfg_data_i;
        RegLimit: lim_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  jet_front u_front (
    .clk_i, .rst_ni, .push_i, .full_o,
    .pixel_row_i, .pixel_col_i,
    .zoom_i(zoom_q), .ctr_x_i(cx_q), .ctr_y_i(cy_q),
    .out_valid_o(f_v), .out_ready_i(f_r), .out_data_o(f_d)
  );

  jet_fifo u_fifo (
    .clk_i, .rst_ni, .wr_i(f_v), .wr_ready_o(f_r), .wr_data_i(f_d),
    .rd_valid_o(q_v), .rd_i(q_r), .rd_data_o(q_d)
  );

  jet_back u_back (
    .clk_i, .rst_ni, .in_valid_i(q_v), .in_ready_o(q_r), .in_data_i(q_d),
    .c_re_i(cre_q), .c_im_i(cim_q), .limit_i(lim_q),
    .empty_o, .pop_i, .escape_count_o
  );
endmodule

/* rtl/jet_checker.sv */
// -----------------------------------------------------------------------------
// jet_checker
// Port-level checks of the pixel unit.
// -----------------------------------------------------------------------------
`include "julia_escape_time_pixel_unit_macros.svh"
module jet_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        push_i,
  input logic        full_o,
  input logic        empty_o,
  input logic        pop_i,
  input logic [15:0] escape_count_o
);
  // Hold a waiting result until it is taken
  `JET_ASSERT_NEXT(a_hold, clk_i, rst_ni, !empty_o && !pop_i, !empty_o)
  `JET_ASSERT_NEXT(a_stable, clk_i, rst_ni, !empty_o && !pop_i, $stable(escape_count_o))
  // An accepted pixel keeps the input side busy next cycle
  `JET_ASSERT_NEXT(a_busy, clk_i, rst_ni, push_i && !full_o, full_o)
endmodule

bind julia_escape_time_pixel_unit jet_checker u_chk (
  .clk_i, .rst_ni, .push_i, .full_o, .empty_o, .pop_i, .escape_count_o
);

/* test/tb_julia_escape_time_pixel_unit.sv */
// -----------------------------------------------------------------------------
// tb_julia_escape_time_pixel_unit
// Self-checking bench for the Julia escape-time pixel unit.
// Pixels are pushed from a queue with random gaps. Each accepted pixel is
// scored by an in-bench escape-count model, and popped counts are compared in
// order. The zoom, centre, constant and iteration limit registers are swept
// between batches, with their extremes included.
// -----------------------------------------------------------------------------
module tb_julia_escape_time_pixel_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import jet_pkg::*;

  localparam longint QMax = 64'sd2147483647;
  localparam longint QMin = -64'sd2147483648;
  localparam int WatchLimit = 400000;

  typedef struct packed {
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
  } pixel_t;

  logic clk_i;
  logic rst_ni;
  logic push_i;
  logic full_o;
  logic [RowW-1:0] pixel_row_i;
  logic [ColW-1:0] pixel_col_i;
  logic empty_o;
  logic pop_i;
  logic [CntW-1:0] escape_count_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [2:0] cfg_index_i;
  logic [31:0] cfg_data_i;

  // Shadow of the block's registers
  logic [31:0] zoom_q;
  longint ctr_x, ctr_y, c_re, c_im;
  logic [15:0] iter_limit;

  pixel_t pending_pixels[$];
  logic [CntW-1:0] expected_counts[$];
  int fails;
  int popped;
  bit calm;
  bit long_hold_done;

  julia_escape_time_pixel_unit dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint sat_q32(input longint v);
    if (v > QMax) return QMax;
    if (v < QMin) return QMin;
    return v;
  endfunction

  // Map a pixel offset to a Q4.28 start coordinate
  function automatic longint start_point(input longint n, input longint d,
                                         input longint ctr);
    longint unsigned zm, mag, den, q;
    longint v;
    zm = (zoom_q == 0) ? 64'd1 : {32'd0, zoom_q};
    mag = longint'(n < 0 ? -n : n) << 44;
    den = d * zm;
    q = mag / den;
    if (n < 0) v = (q > (64'd1 << 31)) ? QMin : -longint'(q);
    else v = (q > QMax) ? QMax : longint'(q);
    return sat_q32(v - ctr);
  endfunction

  // Iterate z = z^2 + c until escape or the limit
  function automatic logic [CntW-1:0] escape_count(input pixel_t p);
    longint x, y, nr, ni;
    longint unsigned mag2;
    int unsigned cnt;
    x = start_point((longint'(p.col) - Cols / 2 + 1) * 2, ColDen, ctr_x);
    y = start_point((Rows / 2 - longint'(p.row) - 1) * 2, RowDen, ctr_y);
    cnt = 0;
    while (cnt < iter_limit) begin
      nr = sat_q32(((x * x - y * y) >>> 28) + c_re);
      ni = sat_q32(((x * y) >>> 27) + c_im);
      x = nr;
      y = ni;
      mag2 = longint'(x * x) + longint'(y * y);
      if (mag2 > (64'd4 << 56)) break;
      cnt++;
    end
    return cnt[CntW-1:0];
  endfunction

  // Driver: offer pending pixels, score each accepted one
  int push_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push_i <= 1'b0;
      pixel_row_i <= '0;
      pixel_col_i <= '0;
      push_gap = 0;
    end else begin
      if (push_i && !full_o) begin
        expected_counts.push_back(escape_count(pending_pixels[0]));
        void'(pending_pixels.pop_front());
      end
      if (push_gap == 0 && !calm && $urandom_range(0, 9) == 0)
        push_gap = $urandom_range(1, 11);
      if (push_gap > 0) begin
        push_gap--;
        push_i <= 1'b0;
      end else if (pending_pixels.size() > 0) begin
        push_i <= 1'b1;
        pixel_row_i <= pending_pixels[0].row;
        pixel_col_i <= pending_pixels[0].col;
      end else begin
        push_i <= 1'b0;
      end
    end
  end

  // Monitor: pop with random stalls, check against the oldest expectation
  int pop_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop_i <= 1'b0;
      pop_gap = 0;
      popped = 0;
      long_hold_done = 1'b0;
    end else begin
      if (pop_i && !empty_o) begin
        popped++;
        if (expected_counts.size() == 0) begin
          $display("%0t: unexpected word: expected none, actual %0d", $realtime,
                   escape_count_o);
          fails++;
        end else begin
          if (escape_count_o !== expected_counts[0]) begin
            $display("%0t: escape_count mismatch: expected %0d, actual %0d",
                     $realtime, expected_counts[0], escape_count_o);
            fails++;
          end
          void'(expected_counts.pop_front());
        end
      end
      // hold off once for a long stretch so the input side backs up
      if (!long_hold_done && popped == 40) begin
        long_hold_done = 1'b1;
        pop_gap = 3000;
      end
      if (pop_gap == 0 && !calm && $urandom_range(0, 9) == 0)
        pop_gap = $urandom_range(1, 11);
      if (pop_gap > 0) begin
        pop_gap--;
        pop_i <= 1'b0;
      end else begin
        pop_i <= 1'b1;
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long
  int stuck_cycles;
  always @(posedge clk_i) begin
    if ((push_i && !full_o) || (pop_i && !empty_o) || !rst_ni) stuck_cycles = 0;
    else stuck_cycles++;
    if (stuck_cycles >= WatchLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Present one register word and hold it until taken; the caller drops valid
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      RegZoom:  zoom_q = val;
      RegCtrX:  ctr_x = longint'(signed'(val));
      RegCtrY:  ctr_y = longint'(signed'(val));
      RegCRe:   c_re = longint'(signed'(val));
      RegCIm:   c_im = longint'(signed'(val));
      RegLimit: iter_limit = val[15:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    wait (pending_pixels.size() == 0 && expected_counts.size() == 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_all(input logic [31:0] zm, input logic [31:0] cx,
                         input logic [31:0] cy, input logic [31:0] cr,
                         input logic [31:0] ci, input logic [15:0] lim);
    wait_idle();
    write_reg(RegZoom, zm);
    write_reg(RegCtrX, cx);
    write_reg(RegCtrY, cy);
    write_reg(RegCRe, cr);
    write_reg(RegCIm, ci);
    write_reg(RegLimit, {16'd0, lim});
    cfg_valid_i <= 1'b0;
  endtask

  task automatic add_corners();
    pending_pixels.push_back('{row: 10'd0, col: 10'd0});
    pending_pixels.push_back('{row: 10'd0, col: 10'd1023});
    pending_pixels.push_back('{row: 10'd1023, col: 10'd0});
    pending_pixels.push_back('{row: 10'd1023, col: 10'd1023});
    pending_pixels.push_back('{row: 10'd511, col: 10'd511});
  endtask

  task automatic add_random(input int n);
    repeat (n)
      pending_pixels.push_back('{row: 10'($urandom_range(0, 1023)),
                                 col: 10'($urandom_range(0, 1023))});
  endtask

  int rnd_lim;
  initial begin
    fails = 0;
    calm = 1'b0;
    zoom_q = 32'd65536;
    ctr_x = 0;
    ctr_y = 0;
    c_re = 0;
    c_im = 0;
    iter_limit = 16'd255;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: corners, centre and neighbors
    add_corners();
    pending_pixels.push_back('{row: 10'd512, col: 10'd512});
    pending_pixels.push_back('{row: 10'd511, col: 10'd512});
    pending_pixels.push_back('{row: 10'd341, col: 10'd682});

    // zero zoom, zero limit, extreme centres
    set_all(32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'd0, 16'd0);
    add_corners();

    // max zoom, saturated constant, top limit (escapes at once)
    set_all(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
            32'h8000_0000, 16'hFFFF);
    add_corners();

    // top limit with c = 2.0 so orbits leave within a few steps
    set_all(32'd65536, 32'd0, 32'd0, 32'h2000_0000, 32'd0, 16'hFFFF);
    add_corners();

    // default limit with a classic bounded-region constant
    set_all(32'd65536, 32'd0, 32'd0, 32'hF333_3334, 32'h027E_F9DB, 16'd255);
    add_random(100);

    // random settings, mostly short limits
    for (int ph = 0; ph < 8; ph++) begin
      rnd_lim = (ph % 3 == 2) ? $urandom_range(0, 65535) & 16'h00FF
                              : $urandom_range(1, 40);
      set_all($urandom_range(1 << 14, 1 << 20),
              $urandom_range(0, 1 << 28) - (1 << 27),
              $urandom_range(0, 1 << 28) - (1 << 27),
              (ph == 5) ? $urandom() : $urandom_range(0, 1 << 29) - (1 << 28),
              (ph == 5) ? $urandom() : $urandom_range(0, 1 << 29) - (1 << 28),
              16'(rnd_lim));
      if (ph == 7) begin
        wait_idle();
        calm = 1'b1;
      end
      add_random(110);
    end

    wait (pending_pixels.size() == 0 && expected_counts.size() == 0);
    repeat (50) @(posedge clk_i);
    if (fails == 0 && expected_counts.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
